/* rtl/tmp_pkg.sv */
// shared constants and types for the trapezoidal motion profile block
// no dependencies
package tmp_pkg;
    localparam int VALUE_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_BITS  = 2 * VALUE_BITS;
    localparam int CNT_BITS   = $clog2(PROD_BITS + 1);

    localparam logic signed [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    typedef enum logic [1:0] {
        PH_DONE  = 2'd0,
        PH_ACCEL = 2'd1,
        PH_CRUISE = 2'd2,
        PH_DECEL = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        REG_DIST  = 2'd0,
        REG_VCRU  = 2'd1,
        REG_VEND  = 2'd2,
        REG_ACCEL = 2'd3
    } reg_idx_t;

    // operation request to the shared arithmetic unit
    typedef struct packed {
        logic                         start;
        logic                         do_div;
        logic signed [VALUE_BITS:0]   a;
        logic signed [VALUE_BITS:0]   b;
        logic signed [VALUE_BITS+1:0] d;
        logic [CNT_BITS-1:0]          sh;
    } alu_req_t;

    typedef struct packed {
        logic                        done;
        logic signed [VALUE_BITS-1:0] res;
    } alu_rsp_t;

    function automatic logic signed [VALUE_BITS-1:0] sat_add(
        input logic signed [VALUE_BITS:0] v);
        logic signed [VALUE_BITS:0] hi;
        logic signed [VALUE_BITS:0] lo;
        hi = {VMAX[VALUE_BITS-1], VMAX};
        lo = {VMIN[VALUE_BITS-1], VMIN};
        if (v > hi)      return VMAX;
        else if (v < lo) return VMIN;
        else             return v[VALUE_BITS-1:0];
    endfunction
endpackage

/* rtl/tmp_alu.sv */
// shared shift-add multiplier and restoring divider, one bit per cycle
// computes (a*b)>>sh or (a*b)/d, truncated toward zero and saturated; uses tmp_pkg
module tmp_alu
    import tmp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  alu_req_t req,
    output alu_rsp_t rsp
);
    localparam int MB = VALUE_BITS + 1;
    localparam int WB = 2 * MB;
    localparam int DB = VALUE_BITS + 2;

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIN} st_t;

    st_t                 st_reg;
    logic [CNT_BITS:0]   cnt_reg;
    logic [WB-1:0]       prod_reg;
    logic [MB-1:0]       mcand_reg;
    logic [MB-1:0]       mplier_reg;
    logic [DB-1:0]       dm_reg;
    logic [DB:0]         rem_reg;
    logic [WB-1:0]       quo_reg;
    logic                neg_reg;
    logic                div_reg;
    logic                dz_reg;
    logic [CNT_BITS-1:0] sh_reg;
    logic signed [VALUE_BITS-1:0] res_reg;
    logic                done_reg;

    logic [MB-1:0] am, bm;
    logic [DB-1:0] dmag;
    logic [DB:0]   rtry;
    logic [WB-1:0] mag;
    logic          ovf;

    assign am   = req.a[MB-1] ? MB'(-req.a) : MB'(req.a);
    assign bm   = req.b[MB-1] ? MB'(-req.b) : MB'(req.b);
    assign dmag = req.d[DB-1] ? DB'(-req.d) : DB'(req.d);
    assign rtry = {rem_reg[DB-1:0], prod_reg[WB-1]};

    always_comb
    begin
        mag = div_reg ? quo_reg : (prod_reg >> sh_reg);
        ovf = (mag > WB'(VMAX));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE:
                begin
                    if (req.start)
                    begin
                        mcand_reg  <= am;
                        mplier_reg <= bm;
                        prod_reg   <= '0;
                        dm_reg     <= dmag;
                        rem_reg    <= '0;
                        quo_reg    <= '0;
                        div_reg    <= req.do_div;
                        dz_reg     <= (dmag == '0);
                        sh_reg     <= req.sh;
                        neg_reg    <= (req.a[MB-1] ^ req.b[MB-1])
                                      ^ (req.do_div & req.d[DB-1]);
                        cnt_reg    <= (CNT_BITS+1)'(MB);
                        st_reg     <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    // msb-first shift and add
                    prod_reg   <= (prod_reg << 1)
                                  + (mplier_reg[MB-1] ? WB'(mcand_reg) : WB'(0));
                    mplier_reg <= mplier_reg << 1;
                    cnt_reg    <= cnt_reg - 1'b1;
                    if (cnt_reg == (CNT_BITS+1)'(1))
                    begin
                        if (div_reg && !dz_reg)
                        begin
                            cnt_reg <= (CNT_BITS+1)'(WB);
                            st_reg  <= S_DIV;
                        end
                        else
                        begin
                            st_reg <= S_FIN;
                        end
                    end
                end
                S_DIV:
                begin
                    prod_reg <= prod_reg << 1;
                    cnt_reg  <= cnt_reg - 1'b1;
                    if (rtry >= {1'b0, dm_reg})
                    begin
                        rem_reg <= rtry - {1'b0, dm_reg};
                        quo_reg <= {quo_reg[WB-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rtry;
                        quo_reg <= {quo_reg[WB-2:0], 1'b0};
                    end
                    if (cnt_reg == (CNT_BITS+1)'(1))
                        st_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (div_reg && dz_reg)
                        res_reg <= (prod_reg == '0) ? '0 : (neg_reg ? VMIN : VMAX);
                    else if (ovf)
                        res_reg <= neg_reg ? VMIN : VMAX;
                    else
                        res_reg <= neg_reg ? -mag[VALUE_BITS-1:0] : mag[VALUE_BITS-1:0];
                    done_reg <= 1'b1;
                    st_reg   <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;
endmodule

/* rtl/trapezoidal_motion_profile.sv */
// trapezoidal motion profile generator, top level
// sequencer around the shared arithmetic unit tmp_alu; uses tmp_pkg
//
// usage: write move_distance, cruise_velocity, end_velocity and
// ramp_acceleration on the cfg channel (index 0..3) while idle, then send
// a beat with start_req=1 to load the move, followed by tick beats
// (start_req=0) carrying time_step. every input beat gives one result beat
// of position_delta, motion_phase and velocity_now.
// work per beat: a start beat or a tick while finished goes straight to the
// output register; a decelerating tick runs two multiplies on the shared
// unit plus the ramp and output steps, a cruising tick the braking test
// divide and one multiply, an accelerating tick the divide and two
// multiplies, and a tick where braking begins a second divide for the
// deceleration. the next beat is taken in the cycle after the result is
// loaded. the block accepts one beat at a time; in_stall is high from
// acceptance until the result is loaded into the output register, and
// stays high while an earlier result still waits there under out_stall.
// out_valid holds with a stable payload while out_stall is high. reset
// clears the configuration and motion state to zero, the phase to finished
// and out_valid; tick scratch and output payload registers are not reset.
module trapezoidal_motion_profile
    import tmp_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [31:0]                  cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         start_req,
    input  logic [30:0]                  time_step,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [31:0]           position_delta,
    output logic [1:0]                   motion_phase,
    output logic signed [31:0]           velocity_now
);
    localparam int VB = VALUE_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_NEED, S_NEED_W, S_BRAKE, S_BRAKE_W, S_DV, S_DV_W, S_CRUISE,
        S_RAMP, S_DELTA_W, S_FINISH, S_OUT
    } st_t;

    st_t st_reg;
    logic signed [VB-1:0] cfg_dist_reg, cfg_vcru_reg, cfg_vend_reg, cfg_acc_reg;
    logic signed [VB-1:0] dleft_reg, vcur_reg, vtgt_reg, vend_reg, acc_reg;
    phase_t               phase_reg;
    logic signed [VB-1:0] dt_reg, dv_reg, vn_reg, delta_reg;
    logic                 out_valid_reg;
    logic signed [31:0]   pd_out_reg, vel_out_reg;
    phase_t               ph_out_reg;

    alu_req_t req;
    alu_rsp_t rsp;

    logic signed [VB-1:0] cfg_v;
    logic signed [VB:0]   sum_v, dif_v;
    logic signed [VB-1:0] vup, vdn, dl_new;

    assign cfg_v = VB'(signed'(cfg_data));
    assign sum_v = {vcur_reg[VB-1], vcur_reg} + {vend_reg[VB-1], vend_reg};
    assign dif_v = {vcur_reg[VB-1], vcur_reg} - {vend_reg[VB-1], vend_reg};
    assign vup   = sat_add({vcur_reg[VB-1], vcur_reg} + {dv_reg[VB-1], dv_reg});
    assign vdn   = sat_add({vcur_reg[VB-1], vcur_reg} - {dv_reg[VB-1], dv_reg});
    assign dl_new = sat_add({dleft_reg[VB-1], dleft_reg} - {rsp.res[VB-1], rsp.res});

    tmp_alu u_alu (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    assign cfg_ready = (st_reg == S_IDLE);
    assign in_stall  = (st_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign position_delta = pd_out_reg;
    assign motion_phase   = ph_out_reg;
    assign velocity_now   = vel_out_reg;

    always_comb
    begin
        req = '0;
        req.sh = CNT_BITS'(FRAC_BITS);
        unique case (st_reg)
            S_NEED:
            begin
                req.start  = 1'b1;
                req.do_div = 1'b1;
                req.a = sum_v;
                req.b = dif_v;
                req.d = {acc_reg[VB-1], acc_reg, 1'b0};
            end
            S_BRAKE:
            begin
                req.start  = 1'b1;
                req.do_div = 1'b1;
                req.a = sum_v;
                req.b = dif_v;
                req.d = {dleft_reg[VB-1], dleft_reg, 1'b0};
            end
            S_DV:
            begin
                req.start = 1'b1;
                req.a = {acc_reg[VB-1], acc_reg};
                req.b = {1'b0, dt_reg};
            end
            S_CRUISE:
            begin
                req.start = 1'b1;
                req.a = {vcur_reg[VB-1], vcur_reg};
                req.b = {1'b0, dt_reg};
            end
            S_RAMP:
            begin
                req.start = 1'b1;
                req.a = {vcur_reg[VB-1], vcur_reg} + {vn_reg[VB-1], vn_reg};
                req.b = {1'b0, dt_reg};
                req.sh = CNT_BITS'(FRAC_BITS + 1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            cfg_dist_reg  <= '0;
            cfg_vcru_reg  <= '0;
            cfg_vend_reg  <= '0;
            cfg_acc_reg   <= '0;
            dleft_reg     <= '0;
            vcur_reg      <= '0;
            vtgt_reg      <= '0;
            vend_reg      <= '0;
            acc_reg       <= '0;
            phase_reg     <= PH_DONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (reg_idx_t'(cfg_index))
                    REG_DIST:  cfg_dist_reg <= cfg_v;
                    REG_VCRU:  cfg_vcru_reg <= cfg_v;
                    REG_VEND:  cfg_vend_reg <= cfg_v;
                    REG_ACCEL: cfg_acc_reg  <= cfg_v;
                    default: ;
                endcase
            end
            unique case (st_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        dt_reg    <= VB'({1'b0, time_step});
                        delta_reg <= '0;
                        if (start_req)
                        begin
                            dleft_reg <= cfg_dist_reg;
                            vtgt_reg  <= cfg_vcru_reg;
                            vend_reg  <= cfg_vend_reg;
                            acc_reg   <= cfg_acc_reg;
                            if (cfg_dist_reg <= 0 || cfg_vcru_reg <= 0 ||
                                cfg_acc_reg <= 0 || cfg_vend_reg < 0)
                                phase_reg <= PH_DONE;
                            else
                                phase_reg <= PH_ACCEL;
                            st_reg <= S_OUT;
                        end
                        else if (phase_reg == PH_DONE)
                            st_reg <= S_OUT;
                        else if (phase_reg == PH_DECEL)
                            st_reg <= S_DV;
                        else
                            st_reg <= S_NEED;
                    end
                end
                S_NEED:   st_reg <= S_NEED_W;
                S_NEED_W:
                begin
                    if (rsp.done)
                    begin
                        if (dleft_reg <= rsp.res)
                        begin
                            phase_reg <= PH_DECEL;
                            vtgt_reg  <= vend_reg;
                            st_reg    <= S_BRAKE;
                        end
                        else if (phase_reg == PH_ACCEL)
                            st_reg <= S_DV;
                        else
                        begin
                            // cruising keeps its velocity
                            vn_reg <= vcur_reg;
                            st_reg <= S_CRUISE;
                        end
                    end
                end
                S_BRAKE:  st_reg <= S_BRAKE_W;
                S_BRAKE_W:
                begin
                    if (rsp.done)
                    begin
                        acc_reg <= rsp.res;
                        st_reg  <= S_DV;
                    end
                end
                S_DV:     st_reg <= S_DV_W;
                S_DV_W:
                begin
                    if (rsp.done)
                    begin
                        dv_reg <= rsp.res;
                        st_reg <= S_FINISH;
                    end
                end
                S_CRUISE: st_reg <= S_DELTA_W;
                S_FINISH:
                begin
                    // velocity ramp with overshoot clamp
                    vn_reg <= vcur_reg;
                    if (vcur_reg < vtgt_reg)
                    begin
                        if (vup >= vtgt_reg)
                        begin
                            vn_reg    <= vtgt_reg;
                            phase_reg <= PH_CRUISE;
                        end
                        else
                            vn_reg <= vup;
                    end
                    else if (vcur_reg > vtgt_reg)
                    begin
                        if (vdn <= vtgt_reg)
                        begin
                            phase_reg <= (vdn <= vend_reg) ? PH_DONE : PH_CRUISE;
                            vn_reg    <= vtgt_reg;
                        end
                        else
                            vn_reg <= vdn;
                    end
                    st_reg <= S_RAMP;
                end
                S_RAMP: st_reg <= S_DELTA_W;
                S_DELTA_W:
                begin
                    if (rsp.done)
                    begin
                        delta_reg <= rsp.res;
                        dleft_reg <= dl_new;
                        if (dl_new <= 0)
                        begin
                            phase_reg <= PH_DONE;
                            vcur_reg  <= (vn_reg > vend_reg) ? vend_reg : vn_reg;
                        end
                        else
                            vcur_reg <= vn_reg;
                        st_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        pd_out_reg    <= delta_reg;
                        ph_out_reg    <= phase_reg;
                        vel_out_reg   <= vcur_reg;
                        st_reg        <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
            if (out_valid_reg && !out_stall && st_reg != S_OUT)
                out_valid_reg <= 1'b0;
        end
    end
endmodule
